>>> rtl/core/sinf_pkg.sv
// Shared constants for the 3x3 sigma-threshold impulse noise filter.
// No dependencies; imported by sinf_div9 and the top level.
package sinf_pkg;

	// Default window pixel width
	localparam int unsigned PIXEL_BITS_DEF = 12;

	// Bits a sum of nine terms grows by (9 < 16)
	localparam int unsigned SUM_GROWTH = 4;

	// threshold_scale register: unsigned Q4.8
	localparam int unsigned SCALE_BITS = 12;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(320);

	// a = 9 * m * m, kept as one word
	localparam int unsigned A_BITS = 2 * SCALE_BITS + SUM_GROWTH;
	localparam logic [A_BITS-1:0] A_RESET = A_BITS'(9 * 320 * 320);

	// Left side of the test carries a factor of 2^19 (two Q8 scales and divisor 8)
	localparam int unsigned LHS_SHIFT = 19;

endpackage

>>> rtl/core/sinf_div9.sv
// Truncating divide by nine of a window sum, by reciprocal multiplication.
// Depends on sinf_pkg for the default pixel width and the sum growth constant.
module sinf_div9 import sinf_pkg::*; #(
	parameter int unsigned IN_W = PIXEL_BITS_DEF + SUM_GROWTH
) (
	input  logic [IN_W-1:0]            sum,
	output logic [IN_W-SUM_GROWTH-1:0] quot
);

	// k = IN_W + 4 keeps e * sum < 2^k, so the product shifted right is exact
	localparam int unsigned K      = IN_W + SUM_GROWTH;
	localparam int unsigned MW     = IN_W + 2;
	localparam int unsigned PRW    = IN_W + MW;
	localparam int unsigned OUT_W  = IN_W - SUM_GROWTH;
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'd8) / 64'd9);

	logic [PRW-1:0] prod;

	assign prod = {{MW{1'b0}}, sum} * {{IN_W{1'b0}}, RECIP};
	assign quot = prod[K +: OUT_W];

endmodule

>>> rtl/core/sigma_impulse_noise_filter_3x3_top.sv
// Top level of the 3x3 sigma-threshold impulse noise filter: five-stage pipeline.
// Depends on sinf_pkg and sinf_div9.
//
// Usage
//   Input channel (in_valid / in_stall): one transaction carries a full 3x3
//   neighbourhood plus on_border. Output channel (out_valid / out_stall): one
//   transaction per input, carrying filtered_pixel, removed_amount, was_replaced.
//   Config channel (cfg_valid / cfg_ready): writes threshold_scale (Q4.8);
//   cfg_ready is always high. Write it only while the pipeline is empty.
// Pipeline and throughput
//   Five register stages. A transaction accepted into stage 1 passes through
//   stages 2, 3 and 4 into the stage 5 output register. One transaction per
//   cycle is sustained while out_stall is low; four multiplier levels, one per
//   stage (squares, S*S, d*d, a*v), and the final wide compare set the depth.
// Stalls
//   Each stage advances when it is empty or the next stage advances, so bubbles
//   close up and a held result does not stop upstream stages filling. in_stall
//   rises only when all five stages hold data and out_stall is high.
// Reset
//   arst_n clears every stage valid and sets threshold_scale to 1.25 (320).
module sigma_impulse_noise_filter_3x3_top import sinf_pkg::*; #(
	parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [SCALE_BITS-1:0]  threshold_scale,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PIXEL_BITS-1:0]  pix_top_left,
	input  logic [PIXEL_BITS-1:0]  pix_top,
	input  logic [PIXEL_BITS-1:0]  pix_top_right,
	input  logic [PIXEL_BITS-1:0]  pix_left,
	input  logic [PIXEL_BITS-1:0]  pix_centre,
	input  logic [PIXEL_BITS-1:0]  pix_right,
	input  logic [PIXEL_BITS-1:0]  pix_bottom_left,
	input  logic [PIXEL_BITS-1:0]  pix_bottom,
	input  logic [PIXEL_BITS-1:0]  pix_bottom_right,
	input  logic                   on_border,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PIXEL_BITS-1:0]  filtered_pixel,
	output logic signed [PIXEL_BITS:0] removed_amount,
	output logic                   was_replaced
);

	// Word widths, all following from the pixel width
	localparam int unsigned P   = PIXEL_BITS;
	localparam int unsigned SW  = P + SUM_GROWTH;       // window sum S
	localparam int unsigned SQW = 2 * P;                // one square
	localparam int unsigned QW  = 2 * P + SUM_GROWTH;   // sum of squares Q
	localparam int unsigned NW  = 2 * SW;               // 9Q and S*S
	localparam int unsigned DW  = P + 3;                // d = 9c - S when d >= 0
	localparam int unsigned VW  = 2 * P + 7;            // v = 9Q - S*S
	localparam int unsigned LW  = 2 * DW + LHS_SHIFT;   // 2^19 * d * d
	localparam int unsigned PW  = A_BITS + VW;          // a * v

	// ------------------------------------------------------------------
	// Configuration: hold the scale and the derived a = 9*m*m
	// ------------------------------------------------------------------
	logic [SCALE_BITS-1:0]   scale_q;
	logic [2*SCALE_BITS-1:0] msq;
	logic [A_BITS-1:0]       a_q;

	assign cfg_ready = 1'b1;
	assign msq       = {{SCALE_BITS{1'b0}}, scale_q} * {{SCALE_BITS{1'b0}}, scale_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			a_q     <= A_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				scale_q <= threshold_scale;
			end
			// a is registered; user must keep pipeline empty across a write (unchecked)
			a_q <= {msq, 3'b000} + A_BITS'(msq);
		end
	end

	// ------------------------------------------------------------------
	// Flow control: a stage advances when empty or when the next advances
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	assign en5      = !vld_s5 || !out_stall;
	assign en4      = !vld_s4 || en5;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: window sum S and the nine squares
	// ------------------------------------------------------------------
	logic [P-1:0]   pix [9];
	logic [SW-1:0]  sum_c;
	logic [SQW-1:0] sq_c [9];

	logic [SQW-1:0] sq_s1 [9];
	logic [SW-1:0]  sum_s1;
	logic [P-1:0]   centre_s1;
	logic           border_s1;

	assign pix[0] = pix_top_left;
	assign pix[1] = pix_top;
	assign pix[2] = pix_top_right;
	assign pix[3] = pix_left;
	assign pix[4] = pix_centre;
	assign pix[5] = pix_right;
	assign pix[6] = pix_bottom_left;
	assign pix[7] = pix_bottom;
	assign pix[8] = pix_bottom_right;

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < 9; k++) begin
			sum_c    = sum_c + SW'(pix[k]);
			sq_c[k]  = {{P{1'b0}}, pix[k]} * {{P{1'b0}}, pix[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sq_s1     <= sq_c;
			sum_s1    <= sum_c;
			centre_s1 <= pix_centre;
			border_s1 <= on_border;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: Q, S*S, d = 9c - S and floor(S/9)
	// ------------------------------------------------------------------
	logic [QW-1:0] qsum_c;
	logic [SW-1:0] nine_c;
	logic [SW-1:0] d_full;
	logic [P-1:0]  mean_c;

	logic [QW-1:0] qsum_s2;
	logic [NW-1:0] ssq_s2;
	logic [DW-1:0] d_s2;
	logic          dneg_s2;
	logic [P-1:0]  mean_s2;
	logic [P-1:0]  centre_s2;
	logic          border_s2;

	always_comb begin
		qsum_c = '0;
		for (int k = 0; k < 9; k++) begin
			qsum_c = qsum_c + QW'(sq_s1[k]);
		end
	end

	assign nine_c = {centre_s1, 3'b000} + SW'(centre_s1);
	assign d_full = nine_c - sum_s1;

	sinf_div9 #(
		.IN_W (SW)
	) u_div9 (
		.sum  (sum_s1),
		.quot (mean_c)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			qsum_s2   <= qsum_c;
			ssq_s2    <= {{SW{1'b0}}, sum_s1} * {{SW{1'b0}}, sum_s1};
			d_s2      <= d_full[DW-1:0];
			dneg_s2   <= nine_c < sum_s1;
			mean_s2   <= mean_c;
			centre_s2 <= centre_s1;
			border_s2 <= border_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: v = 9Q - S*S (never negative) and d*d
	// ------------------------------------------------------------------
	logic [NW-1:0]   v_full;
	logic [VW-1:0]   v_s3;
	logic [2*DW-1:0] dsq_s3;
	logic            dneg_s3;
	logic [P-1:0]    mean_s3;
	logic [P-1:0]    centre_s3;
	logic            border_s3;

	assign v_full = ({qsum_s2, 3'b000} + NW'(qsum_s2)) - ssq_s2;

	always_ff @(posedge clk) begin
		if (en3) begin
			v_s3      <= v_full[VW-1:0];
			dsq_s3    <= {{DW{1'b0}}, d_s2} * {{DW{1'b0}}, d_s2};
			dneg_s3   <= dneg_s2;
			mean_s3   <= mean_s2;
			centre_s3 <= centre_s2;
			border_s3 <= border_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: right side a*v, left side 2^19 * d*d
	// ------------------------------------------------------------------
	logic [PW-1:0] prod_s4;
	logic [LW-1:0] lhs_s4;
	logic          dneg_s4;
	logic [P-1:0]  mean_s4;
	logic [P-1:0]  centre_s4;
	logic          border_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			prod_s4   <= {{VW{1'b0}}, a_q} * {{A_BITS{1'b0}}, v_s3};
			lhs_s4    <= {dsq_s3, {LHS_SHIFT{1'b0}}};
			dneg_s4   <= dneg_s3;
			mean_s4   <= mean_s3;
			centre_s4 <= centre_s3;
			border_s4 <= border_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5 (output register): keep test and result selection
	// keep when on_border, d < 0 or lhs < a*v; a zero scale never keeps an interior d >= 0 centre
	// ------------------------------------------------------------------
	logic         keep_c;
	logic         replace_c;
	logic [P-1:0] result_c;

	logic [P-1:0]        filtered_s5;
	logic signed [P:0]   removed_s5;
	logic                replaced_s5;

	assign keep_c    = PW'(lhs_s4) < prod_s4;
	assign replace_c = !border_s4 && !dneg_s4 && !keep_c;
	assign result_c  = replace_c ? mean_s4 : centre_s4;

	always_ff @(posedge clk) begin
		if (en5) begin
			filtered_s5 <= result_c;
			removed_s5  <= signed'({1'b0, centre_s4} - {1'b0, result_c});
			replaced_s5 <= replace_c;
		end
	end

	assign filtered_pixel = filtered_s5;
	assign removed_amount = removed_s5;
	assign was_replaced   = replaced_s5;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A kept centre removes nothing
	a_kept_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !was_replaced |-> removed_amount == '0)
		else $error("kept centre with non-zero removed amount");

	// Replacement only happens at or above the mean, so the amount is never negative
	a_repl_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_replaced |-> !removed_amount[P])
		else $error("replaced centre with negative removed amount");

	// Input is held off only when every stage is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_stall))
		else $error("input stalled with room in the pipeline");

	// A freely draining output never holds off the input
	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is not stalled");

endmodule
